// ===== hdl/teq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timed event queue package
// Shared types, operation codes and status codes of the timed event queue.
// ----------------------------------------------------------------------------
package teq_pkg;

  localparam int QueueDepthDefault = 16;
  localparam logic [31:0] WinAhead = 32'h8000_0000;
  localparam logic [31:0] WinLate  = 32'h1000_0000;

  typedef enum logic [2:0] {
    OP_ADD    = 3'd0,
    OP_POP    = 3'd1,
    OP_REMOVE = 3'd2,
    OP_QUERY  = 3'd3,
    OP_REBASE = 3'd4,
    OP_CLEAR  = 3'd5,
    OP_SETSD  = 3'd6,
    OP_NONE   = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DUP      = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic        do_insert;  // insert the new beat at ins_pos
    logic        do_remove;  // remove the entry at rem_pos
    logic        do_rebase;  // rebase all counts
    logic        do_clear;   // drop all entries
    logic [11:0] new_type;
    logic [31:0] new_count;
    logic [31:0] now_count;
    logic [31:0] base_count;
    logic [11:0] special_code;
    logic        spec_ready;
  } cell_ctrl_t;

  // Entry carried between neighboring cells.
  typedef struct packed {
    logic        valid;
    logic [11:0] etype;
    logic [31:0] ecount;
  } entry_t;

  // True when count a fires before entry (b, tb).
  function automatic logic is_before(input logic [31:0] a, input logic [31:0] b,
                                     input logic [11:0] tb, input logic [31:0] now,
                                     input logic [11:0] special_code,
                                     input logic spec_ready);
    logic [31:0] da;
    logic [31:0] db;
    logic [31:0] lag;
    logic        res;
    da  = a - now;
    db  = b - now;
    lag = now - b;
    if (da >= WinAhead) res = 1'b0;
    else if (db < WinAhead) res = (da < db);
    else if (lag < WinLate) res = (tb == special_code) ? spec_ready : 1'b0;
    else res = 1'b1;
    return res;
  endfunction

endpackage

// ===== hdl/teq_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timed event queue cell
// Holds one entry, reports its match flags and shifts with its neighbors.
// ----------------------------------------------------------------------------
module teq_cell (
  input  logic                clk,
  input  logic                rst,
  input  teq_pkg::cell_ctrl_t ctrl,
  input  logic                ins_here,   // new entry lands in this cell
  input  logic                ins_below,  // insert point is above: shift down
  input  logic                rem_above,  // removal point is at or above: shift up
  input  teq_pkg::entry_t     prev_entry,
  input  teq_pkg::entry_t     next_entry,
  output teq_pkg::entry_t     entry,
  output logic                type_hit,
  output logic                new_before
);
  import teq_pkg::*;

  logic        valid;
  logic [11:0] etype;
  logic [31:0] ecount;

  assign entry    = '{valid: valid, etype: etype, ecount: ecount};
  assign type_hit = valid && (etype == ctrl.new_type);
  assign new_before = valid && is_before(ctrl.new_count, ecount, etype, ctrl.now_count,
                                         ctrl.special_code, ctrl.spec_ready);

  // Valid bit.
  always_ff @(posedge clk) begin
    if (rst || ctrl.do_clear) begin
      valid <= 1'b0;
    end else if (ctrl.do_insert && ins_here) begin
      valid <= 1'b1;
    end else if (ctrl.do_insert && ins_below) begin
      valid <= prev_entry.valid;
    end else if (ctrl.do_remove && rem_above) begin
      valid <= next_entry.valid;
    end
  end

  // Payload.
  always_ff @(posedge clk) begin
    if (ctrl.do_insert && ins_here) begin
      etype  <= ctrl.new_type;
      ecount <= ctrl.new_count;
    end else if (ctrl.do_insert && ins_below) begin
      etype  <= prev_entry.etype;
      ecount <= prev_entry.ecount;
    end else if (ctrl.do_remove && rem_above) begin
      etype  <= next_entry.etype;
      ecount <= next_entry.ecount;
    end else if (ctrl.do_rebase) begin
      ecount <= ecount - ctrl.now_count + ctrl.base_count;
    end
  end

endmodule

// ===== hdl/timed_event_queue_wrapping.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timed event queue with wraparound ordering
// Sorted queue of timed events held in a chain of cells.
// ----------------------------------------------------------------------------
// Each accepted operation passes the input register, then the cell-chain compare
// and shift together with the result register, which raises the done strobe.
// No new operation is taken while busy is high.
// Reset: empty queue, special-done set, next interrupt zero, special code 1.
// The receiver cannot stall: the done strobe is high for exactly one cycle.
module timed_event_queue_wrapping #(
  parameter int QUEUE_DEPTH = teq_pkg::QueueDepthDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_we,
  input  logic [11:0] cfg_wdata,
  input  logic [2:0]  op,
  input  logic [11:0] event_type,
  input  logic [31:0] event_count,
  input  logic [31:0] now_count,
  output logic        done,
  output logic [1:0]  status,
  output logic [31:0] found_count,
  output logic [11:0] head_type,
  output logic [31:0] head_count,
  output logic [31:0] next_interrupt,
  output logic        queue_empty,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0] occupancy
);
  import teq_pkg::*;

  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  // Captured beat.
  logic        busy_q;
  op_t         op_q;
  logic [11:0] type_q;
  logic [31:0] cnt_q;
  logic [31:0] now_q;

  logic [11:0] special_code;
  logic        spec_ready;
  logic [31:0] next_fire;
  logic [CW-1:0] total;

  cell_ctrl_t ctrl;
  entry_t     ent [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] hit;
  logic [QUEUE_DEPTH-1:0] precede;
  logic [QUEUE_DEPTH-1:0] ins_here;
  logic [QUEUE_DEPTH-1:0] ins_below;
  logic [QUEUE_DEPTH-1:0] rem_above;

  // Evaluate-phase decisions.
  logic          any_hit;
  logic [IW-1:0] hit_pos;
  logic [CW-1:0] ins_pos;
  logic          is_special;
  logic          sd_eff;
  logic [1:0]    st;
  logic [31:0]   found;
  logic [31:0]   next_fire_next;
  logic [CW-1:0] total_next;
  entry_t        new_head;

  assign busy = busy_q;

  // Input capture and phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= start && !busy_q;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_q) begin
      op_q   <= op_t'(op);
      type_q <= event_type;
      cnt_q  <= event_count;
      now_q  <= now_count;
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      special_code <= 12'd1;
    end else if (cfg_we) begin
      special_code <= cfg_wdata;
    end
  end

  assign is_special = (type_q == special_code);
  // An add while now is above WinAhead clears the special-done flag before any check.
  assign sd_eff = (op_q == OP_ADD && now_q > WinAhead) ? 1'b0 : spec_ready;

  // Priority search over cell flags.
  always_comb begin
    any_hit = 1'b0;
    hit_pos = '0;
    for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
      if (hit[i]) begin
        any_hit = 1'b1;
        hit_pos = IW'(i);
      end
    end
    ins_pos = total;
    if (!is_special) begin
      for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
        if (precede[i]) ins_pos = CW'(i);
      end
    end
  end

  // Operation decode.
  always_comb begin
    st             = ST_OK;
    found          = '0;
    next_fire_next = next_fire;
    total_next     = total;
    ctrl           = '0;
    ctrl.new_type     = type_q;
    ctrl.new_count    = cnt_q;
    ctrl.now_count    = now_q;
    ctrl.base_count   = cnt_q;
    ctrl.special_code = special_code;
    ctrl.spec_ready   = sd_eff;
    new_head       = (total > CW'(1)) ? ent[1] : '0;
    if (busy_q) begin
      case (op_q)
        OP_ADD: begin
          if (any_hit) begin
            st = ST_DUP;
          end else if (total >= CW'(QUEUE_DEPTH)) begin
            st = ST_FULL;
          end else begin
            ctrl.do_insert = 1'b1;
            total_next     = total + CW'(1);
            if (ins_pos == '0) next_fire_next = cnt_q;
          end
        end
        OP_POP: begin
          if (total == '0) begin
            st = ST_NOTFOUND;
          end else begin
            ctrl.do_remove = 1'b1;
            total_next     = total - CW'(1);
            if (new_head.valid && (new_head.ecount > now_q ||
                (now_q - new_head.ecount) < WinAhead))
              next_fire_next = new_head.ecount;
            else
              next_fire_next = '0;
          end
        end
        OP_REMOVE: begin
          if (any_hit) begin
            ctrl.do_remove = 1'b1;
            total_next     = total - CW'(1);
          end else begin
            st = ST_NOTFOUND;
          end
        end
        OP_QUERY: begin
          if (any_hit) found = ent[hit_pos].ecount;
          else st = ST_NOTFOUND;
        end
        OP_REBASE: ctrl.do_rebase = 1'b1;
        OP_CLEAR: begin
          ctrl.do_clear = 1'b1;
          total_next    = '0;
        end
        default: ;
      endcase
    end
  end

  // Per-cell shift controls.
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      ins_here[i]  = (CW'(i) == ins_pos);
      ins_below[i] = (CW'(i) > ins_pos);
      if (op_q == OP_POP) rem_above[i] = 1'b1;
      else rem_above[i] = (IW'(i) >= hit_pos);
    end
  end

  // The cell chain.
  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    entry_t prev_e;
    entry_t next_e;
    if (g == 0) begin : g_first
      assign prev_e = '0;
    end else begin : g_mid
      assign prev_e = ent[g-1];
    end
    if (g == QUEUE_DEPTH - 1) begin : g_last
      assign next_e = '0;
    end else begin : g_rest
      assign next_e = ent[g+1];
    end
    teq_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .ins_here   (ins_here[g]),
      .ins_below  (ins_below[g]),
      .rem_above  (rem_above[g]),
      .prev_entry (prev_e),
      .next_entry (next_e),
      .entry      (ent[g]),
      .type_hit   (hit[g]),
      .new_before (precede[g])
    );
  end

  // Queue state.
  always_ff @(posedge clk) begin
    if (rst) begin
      total      <= '0;
      next_fire  <= '0;
      spec_ready <= 1'b1;
      done       <= 1'b0;
    end else begin
      done <= busy_q;
      if (busy_q) begin
        total     <= total_next;
        next_fire <= next_fire_next;
        if (op_q == OP_SETSD) spec_ready <= 1'b1;
        else spec_ready <= sd_eff;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (busy_q) begin
      status      <= st;
      found_count <= found;
    end
  end

  assign head_type      = ent[0].valid ? ent[0].etype : '0;
  assign head_count     = ent[0].valid ? ent[0].ecount : '0;
  assign next_interrupt = next_fire;
  assign queue_empty    = (total == '0);
  assign occupancy      = total;

  // Checks.
  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    total <= CW'(QUEUE_DEPTH)) else $error("occupancy beyond depth");
  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    busy_q |=> done) else $error("missing result strobe");
  a_head_valid: assert property (@(posedge clk) disable iff (rst)
    (total != '0) == ent[0].valid) else $error("head valid mismatch");
  a_no_double: assert property (@(posedge clk) disable iff (rst)
    busy_q |=> !busy_q) else $error("busy longer than one cycle");

endmodule
